FILE: rtl/dct_pkg.sv
// ----------------------------------------------------------------------------
// Tokenizer package
// Item types, token kind and error codes, character constants and the
// keyword table shared by the tokenizer modules.
// ----------------------------------------------------------------------------
package dct_pkg;

  localparam int OUT_OFF_W    = 16;
  localparam int KW_COUNT     = 9;
  localparam int KW_TEXT_LEN  = 5;
  localparam int SLOT_COUNT   = 3;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QUEUE_AW     = 2;

  // Token kinds
  localparam logic [3:0] TK_INDENT  = 4'd0;
  localparam logic [3:0] TK_NEWLINE = 4'd1;
  localparam logic [3:0] TK_STRING  = 4'd2;
  localparam logic [3:0] TK_INT     = 4'd3;
  localparam logic [3:0] TK_FLOAT   = 4'd4;
  localparam logic [3:0] TK_IDENT   = 4'd5;
  localparam logic [3:0] TK_KEYWORD = 4'd6;
  localparam logic [3:0] TK_OP      = 4'd7;
  localparam logic [3:0] TK_PAREN   = 4'd8;
  localparam logic [3:0] TK_CMP     = 4'd9;
  localparam logic [3:0] TK_COLON   = 4'd10;
  localparam logic [3:0] TK_EOF     = 4'd11;
  localparam logic [3:0] TK_ERROR   = 4'd12;

  // Error codes
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_ILLEGAL    = 3'd1;
  localparam logic [2:0] ERR_UNTERM     = 3'd2;
  localparam logic [2:0] ERR_LETTER_NUM = 3'd3;
  localparam logic [2:0] ERR_SECOND_DOT = 3'd4;
  localparam logic [2:0] ERR_NO_DIGIT   = 3'd5;

  // Characters
  localparam logic [7:0] CH_NUL        = 8'h00;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_NL         = 8'h0A;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_SPACE      = " ";
  localparam logic [7:0] CH_QUOTE      = "\"";
  localparam logic [7:0] CH_DOT        = ".";
  localparam logic [7:0] CH_UNDERSCORE = "_";
  localparam logic [7:0] CH_QUESTION   = "?";
  localparam logic [7:0] CH_COLON      = ":";
  localparam logic [7:0] CH_PLUS       = "+";
  localparam logic [7:0] CH_MINUS      = "-";
  localparam logic [7:0] CH_STAR       = "*";
  localparam logic [7:0] CH_SLASH      = "/";
  localparam logic [7:0] CH_EQUAL      = "=";
  localparam logic [7:0] CH_LPAREN     = "(";
  localparam logic [7:0] CH_RPAREN     = ")";
  localparam logic [7:0] CH_LESS       = "<";
  localparam logic [7:0] CH_GREATER    = ">";
  localparam logic [7:0] CH_BANG       = "!";

  // Keywords if, elif, else, while, var, int, float, print, run
  localparam logic [0:KW_COUNT-1][0:KW_TEXT_LEN-1][7:0] KW_TEXT = '{
    '{"i", "f", 8'h00, 8'h00, 8'h00},
    '{"e", "l", "i", "f", 8'h00},
    '{"e", "l", "s", "e", 8'h00},
    '{"w", "h", "i", "l", "e"},
    '{"v", "a", "r", 8'h00, 8'h00},
    '{"i", "n", "t", 8'h00, 8'h00},
    '{"f", "l", "o", "a", "t"},
    '{"p", "r", "i", "n", "t"},
    '{"r", "u", "n", 8'h00, 8'h00}
  };
  localparam logic [0:KW_COUNT-1][2:0] KW_LEN = '{
    3'd2, 3'd4, 3'd4, 3'd5, 3'd3, 3'd3, 3'd5, 3'd5, 3'd3
  };

  typedef struct packed {
    logic [7:0] in_char;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [3:0]           token_kind;
    logic [3:0]           keyword_id;
    logic [OUT_OFF_W-1:0] start_offset;
    logic [OUT_OFF_W-1:0] end_offset;
    logic [2:0]           error_code;
    logic                 last_result;
  } out_item_t;

  // All tokens caused by one byte, in order
  typedef struct packed {
    logic [1:0]                       cnt;
    out_item_t [SLOT_COUNT-1:0]       tok;
  } bundle_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] id;
  } kw_hit_t;

  function automatic kw_hit_t kw_lookup(input logic [0:KW_TEXT_LEN-1][7:0] pre,
                                        input logic [3:0] len);
    kw_hit_t r;
    logic    eq;
    r = '0;
    for (int i = 0; i < KW_COUNT; i++) begin
      eq = (len == {1'b0, KW_LEN[i]});
      for (int j = 0; j < KW_TEXT_LEN; j++) begin
        if (j < int'(KW_LEN[i]) && pre[j] != KW_TEXT[i][j]) begin
          eq = 1'b0;
        end
      end
      if (eq && !r.hit) begin
        r.hit = 1'b1;
        r.id  = 4'(i);
      end
    end
    return r;
  endfunction

endpackage

FILE: rtl/dsl_character_tokenizer.sv
// ----------------------------------------------------------------------------
// Character tokenizer
// Streaming lexer: source bytes in, tokens with kind and offsets out.
// ----------------------------------------------------------------------------
// Usage: present one source byte per item on the in_ channel; byte 0, or
// end_of_text set on a byte, ends the text. Each byte yields zero to three
// tokens on the out_ channel, the last one flagged by last_result. An eof
// token closes every text that ended without a lexical error; after an
// error token the rest of the text yields nothing.
// Tokens are registered in the bundle queue when the byte that causes them
// is taken and are offered from the queue head. Bytes are taken one per cycle
// while the queue has room; the output stage delivers one token per cycle while
// out_ready is high, so a byte giving two or three tokens holds its queue entry until its last token is taken.
// The front end takes bytes as long as the four-entry bundle queue has
// room, so a stalled receiver backs up into in_ready only once the queue
// is full. Reset (rst_n low at a clock edge) empties the queue and starts
// a new text at offset 0.
// ----------------------------------------------------------------------------
module dsl_character_tokenizer #(
  parameter int OFFSET_BITS     = 16,
  parameter int KEYWORD_MAX_LEN = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  dct_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output dct_pkg::out_item_t out_item
);
  import dct_pkg::*;

  logic    accept, push, pop, full, empty;
  bundle_t bundle, head;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  dct_front #(
    .OFFSET_BITS     (OFFSET_BITS),
    .KEYWORD_MAX_LEN (KEYWORD_MAX_LEN)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_item (in_item),
    .push    (push),
    .bundle  (bundle)
  );

  dct_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (bundle),
    .pop     (pop),
    .head    (head),
    .full    (full),
    .empty   (empty)
  );

  dct_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

FILE: rtl/dct_front.sv
// ----------------------------------------------------------------------------
// Tokenizer front end
// Scans one byte per cycle while the queue has room and gathers the up to three tokens it causes
// into one bundle for the queue.
// ----------------------------------------------------------------------------
module dct_front #(
  parameter int OFFSET_BITS     = 16,
  parameter int KEYWORD_MAX_LEN = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  dct_pkg::in_item_t in_item,
  output logic              push,
  output dct_pkg::bundle_t  bundle
);
  import dct_pkg::*;

  localparam int LW = $clog2(KEYWORD_MAX_LEN + 2);
  localparam int IW = $clog2(KEYWORD_MAX_LEN);
  localparam logic [LW-1:0] LEN_MAX  = LW'(KEYWORD_MAX_LEN);
  localparam logic [LW-1:0] LEN_LONG = LW'(KEYWORD_MAX_LEN + 1);

  typedef enum logic [5:0] {
    M_IDLE    = 6'b000001,
    M_STRING  = 6'b000010,
    M_NUMBER  = 6'b000100,
    M_DOTWAIT = 6'b001000,
    M_IDENT   = 6'b010000,
    M_ERROR   = 6'b100000
  } mode_t;

  mode_t                  mode_r, mode_nxt;
  logic                   pend_r, pend_nxt;
  logic                   anl_r, anl_nxt;
  logic                   dot_r, dot_nxt;
  logic [OFFSET_BITS-1:0] off_r, off_nxt;
  logic [OFFSET_BITS-1:0] tstart_r, tstart_nxt;
  logic [LW-1:0]          len_r, len_nxt;
  logic [7:0]             pre_r   [KEYWORD_MAX_LEN];
  logic [7:0]             pre_nxt [KEYWORD_MAX_LEN];

  logic [7:0]             c;
  logic                   eot;
  logic                   is_digit, is_alpha, is_space, is_word;
  logic [OFFSET_BITS-1:0] pos_inc, fin_pos;
  logic [0:KW_TEXT_LEN-1][7:0] pv_r, pv_n;
  kw_hit_t                kw_r, kw_n;
  out_item_t              ev [4];
  logic [3:0]             ev_v;
  logic                   fall, skip, do_fin, clear;
  logic [2:0]             n;

  function automatic out_item_t mk(input logic [3:0] kind, input logic [3:0] kw,
                                   input logic [OFFSET_BITS-1:0] s,
                                   input logic [OFFSET_BITS-1:0] e,
                                   input logic [2:0] err);
    out_item_t t;
    t.token_kind   = kind;
    t.keyword_id   = kw;
    t.start_offset = OUT_OFF_W'(s);
    t.end_offset   = OUT_OFF_W'(e);
    t.error_code   = err;
    t.last_result  = 1'b0;
    return t;
  endfunction

  assign c        = in_item.in_char;
  assign eot      = in_item.end_of_text;
  assign is_digit = c inside {["0":"9"]};
  assign is_alpha = c inside {["a":"z"], ["A":"Z"]};
  assign is_space = (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
  assign is_word  = is_alpha || is_digit || (c == CH_UNDERSCORE);
  assign pos_inc  = (off_r == '1) ? off_r : off_r + 1'b1;

  always_comb begin
    for (int j = 0; j < KW_TEXT_LEN; j++) begin
      pv_r[j] = pre_r[j];
      pv_n[j] = pre_nxt[j];
    end
  end

  assign kw_r = kw_lookup(pv_r, 4'(len_r));
  assign kw_n = kw_lookup(pv_n, 4'(len_nxt));

  always_comb begin
    mode_nxt   = mode_r;
    pend_nxt   = pend_r;
    anl_nxt    = anl_r;
    dot_nxt    = dot_r;
    off_nxt    = off_r;
    tstart_nxt = tstart_r;
    len_nxt    = len_r;
    pre_nxt    = pre_r;
    for (int i = 0; i < 4; i++) begin
      ev[i] = '0;
    end
    ev_v    = '0;
    fall    = 1'b0;
    skip    = 1'b0;
    do_fin  = 1'b0;
    clear   = 1'b0;
    fin_pos = off_r;

    if (mode_r == M_ERROR) begin
      // Everything up to the end of the text is dropped.
      if (c == CH_NUL || eot) begin
        clear = 1'b1;
      end
    end else if (c == CH_NUL) begin
      do_fin = 1'b1;
      clear  = 1'b1;
    end else begin
      case (mode_r)
        M_STRING: begin
          if (c == CH_QUOTE) begin
            ev[0]    = mk(TK_STRING, 4'd0, tstart_r, pos_inc, ERR_NONE);
            ev_v[0]  = 1'b1;
            mode_nxt = M_IDLE;
          end
        end
        M_DOTWAIT: begin
          if (is_digit) begin
            mode_nxt = M_NUMBER;
          end else begin
            ev[0]    = mk(TK_ERROR, 4'd0, tstart_r, pos_inc, ERR_NO_DIGIT);
            ev_v[0]  = 1'b1;
            mode_nxt = M_ERROR;
          end
        end
        M_NUMBER: begin
          if (is_digit) begin
            mode_nxt = M_NUMBER;
          end else if (c == CH_DOT) begin
            if (dot_r) begin
              ev[0]    = mk(TK_ERROR, 4'd0, tstart_r, pos_inc, ERR_SECOND_DOT);
              ev_v[0]  = 1'b1;
              mode_nxt = M_ERROR;
            end else begin
              dot_nxt  = 1'b1;
              mode_nxt = M_DOTWAIT;
            end
          end else if (is_alpha) begin
            ev[0]    = mk(TK_ERROR, 4'd0, tstart_r, pos_inc, ERR_LETTER_NUM);
            ev_v[0]  = 1'b1;
            mode_nxt = M_ERROR;
          end else begin
            ev[0]    = mk(dot_r ? TK_FLOAT : TK_INT, 4'd0, tstart_r, off_r, ERR_NONE);
            ev_v[0]  = 1'b1;
            mode_nxt = M_IDLE;
            fall     = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_word) begin
            if (len_r < LEN_MAX) begin
              pre_nxt[len_r[IW-1:0]] = c;
              len_nxt = len_r + 1'b1;
            end else begin
              len_nxt = LEN_LONG;
            end
          end else begin
            ev[0]    = mk(kw_r.hit ? TK_KEYWORD : TK_IDENT, kw_r.hit ? kw_r.id : 4'd0,
                          tstart_r, off_r, ERR_NONE);
            ev_v[0]  = 1'b1;
            mode_nxt = M_IDLE;
            fall     = 1'b1;
          end
        end
        M_IDLE: begin
          fall = 1'b1;
        end
        default: begin
          fall = 1'b0;
        end
      endcase

      if (fall) begin
        if (pend_r) begin
          pend_nxt = 1'b0;
          if (c == CH_SPACE) begin
            ev[1]   = mk(TK_INDENT, 4'd0, tstart_r, pos_inc, ERR_NONE);
            ev_v[1] = 1'b1;
            skip    = 1'b1;
          end else begin
            anl_nxt = 1'b0;
          end
        end
        if (!skip) begin
          if (is_space) begin
            if (c == CH_SPACE) begin
              pend_nxt   = 1'b1;
              tstart_nxt = off_r;
            end else if (c == CH_NL) begin
              // A run of newlines collapses to one token.
              if (!anl_nxt) begin
                ev[1]   = mk(TK_NEWLINE, 4'd0, off_r, pos_inc, ERR_NONE);
                ev_v[1] = 1'b1;
                anl_nxt = 1'b1;
              end
            end else begin
              anl_nxt = 1'b0;
            end
          end else begin
            anl_nxt    = 1'b0;
            tstart_nxt = off_r;
            if (c == CH_QUOTE) begin
              mode_nxt = M_STRING;
            end else if (is_digit) begin
              mode_nxt = M_NUMBER;
              dot_nxt  = 1'b0;
            end else if (is_alpha || c == CH_UNDERSCORE) begin
              mode_nxt   = M_IDENT;
              pre_nxt[0] = c;
              len_nxt    = LW'(1);
            end else if (c inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_EQUAL}) begin
              ev[1]   = mk(TK_OP, 4'd0, off_r, pos_inc, ERR_NONE);
              ev_v[1] = 1'b1;
            end else if (c inside {CH_LPAREN, CH_RPAREN}) begin
              ev[1]   = mk(TK_PAREN, 4'd0, off_r, pos_inc, ERR_NONE);
              ev_v[1] = 1'b1;
            end else if (c inside {CH_LESS, CH_GREATER, CH_QUESTION, CH_BANG}) begin
              ev[1]   = mk(TK_CMP, 4'd0, off_r, pos_inc, ERR_NONE);
              ev_v[1] = 1'b1;
            end else if (c == CH_COLON) begin
              ev[1]   = mk(TK_COLON, 4'd0, off_r, pos_inc, ERR_NONE);
              ev_v[1] = 1'b1;
            end else begin
              ev[1]    = mk(TK_ERROR, 4'd0, off_r, pos_inc, ERR_ILLEGAL);
              ev_v[1]  = 1'b1;
              mode_nxt = M_ERROR;
            end
          end
        end
      end

      if (eot) begin
        if (mode_nxt != M_ERROR) begin
          do_fin  = 1'b1;
          fin_pos = pos_inc;
        end
        clear = 1'b1;
      end else begin
        off_nxt = pos_inc;
      end
    end

    // Close any open token at end of text; an eof token follows unless it closed as an error.
    if (do_fin) begin
      case (mode_nxt)
        M_STRING: begin
          ev[2]   = mk(TK_ERROR, 4'd0, tstart_nxt, fin_pos, ERR_UNTERM);
          ev_v[2] = 1'b1;
        end
        M_DOTWAIT: begin
          ev[2]   = mk(TK_ERROR, 4'd0, tstart_nxt, fin_pos, ERR_NO_DIGIT);
          ev_v[2] = 1'b1;
        end
        M_NUMBER: begin
          ev[2]   = mk(dot_nxt ? TK_FLOAT : TK_INT, 4'd0, tstart_nxt, fin_pos, ERR_NONE);
          ev_v[2] = 1'b1;
        end
        M_IDENT: begin
          ev[2]   = mk(kw_n.hit ? TK_KEYWORD : TK_IDENT, kw_n.hit ? kw_n.id : 4'd0,
                       tstart_nxt, fin_pos, ERR_NONE);
          ev_v[2] = 1'b1;
        end
        default: begin
          ev_v[2] = 1'b0;
        end
      endcase
      if (mode_nxt != M_STRING && mode_nxt != M_DOTWAIT) begin
        ev[3]   = mk(TK_EOF, 4'd0, fin_pos, fin_pos, ERR_NONE);
        ev_v[3] = 1'b1;
      end
    end

    if (clear) begin
      mode_nxt   = M_IDLE;
      pend_nxt   = 1'b0;
      anl_nxt    = 1'b0;
      dot_nxt    = 1'b0;
      off_nxt    = '0;
      tstart_nxt = '0;
      len_nxt    = '0;
    end
  end

  // Pack the tokens of this byte into consecutive slots.
  always_comb begin
    bundle = '0;
    n      = 3'd0;
    for (int i = 0; i < 4; i++) begin
      if (ev_v[i] && n < 3'(SLOT_COUNT)) begin
        bundle.tok[n[1:0]] = ev[i];
        n = n + 3'd1;
      end
    end
    if (n != 3'd0) begin
      bundle.tok[n[1:0] - 2'd1].last_result = 1'b1;
    end
    bundle.cnt = n[1:0];
  end

  assign push = accept && (n != 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      pend_r   <= 1'b0;
      anl_r    <= 1'b0;
      dot_r    <= 1'b0;
      off_r    <= '0;
      tstart_r <= '0;
      len_r    <= '0;
    end else if (accept) begin
      mode_r   <= mode_nxt;
      pend_r   <= pend_nxt;
      anl_r    <= anl_nxt;
      dot_r    <= dot_nxt;
      off_r    <= off_nxt;
      tstart_r <= tstart_nxt;
      len_r    <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pre_r <= pre_nxt;
    end
  end

endmodule

FILE: rtl/dct_queue.sv
// ----------------------------------------------------------------------------
// Tokenizer bundle queue
// Short first-in first-out queue of token bundles between the front end
// and the output stage.
// ----------------------------------------------------------------------------
module dct_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  dct_pkg::bundle_t wr_data,
  input  logic             pop,
  output dct_pkg::bundle_t head,
  output logic             full,
  output logic             empty
);
  import dct_pkg::*;

  bundle_t             mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wp_r, rp_r;
  logic [QUEUE_AW:0]   cnt_r;

  assign full  = (cnt_r == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/dct_back.sv
// ----------------------------------------------------------------------------
// Tokenizer output stage
// Hands out the tokens of the bundle at the queue head one per cycle while out_ready is high and
// releases the bundle after its last token has been taken.
// ----------------------------------------------------------------------------
module dct_back (
  input  logic               clk,
  input  logic               rst_n,
  input  dct_pkg::bundle_t   head,
  input  logic               empty,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output dct_pkg::out_item_t out_item
);
  import dct_pkg::*;

  logic [1:0] idx_r;
  logic       last_slot;

  assign out_valid = !empty;
  assign last_slot = (idx_r == head.cnt - 2'd1);
  assign pop       = out_valid && out_ready && last_slot;

  always_comb begin
    case (idx_r)
      2'd0:    out_item = head.tok[0];
      2'd1:    out_item = head.tok[1];
      2'd2:    out_item = head.tok[2];
      default: out_item = head.tok[0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else if (out_valid && out_ready) begin
      idx_r <= last_slot ? 2'd0 : idx_r + 2'd1;
    end
  end

endmodule
